// ===== sv/rnp_pkg.sv =====
// ----------------------------------------------------------------------------
// rnp_pkg
// Shared types, register indexes and character codes of the ringtone note
// parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rnp_pkg;

  localparam int unsigned WholeW = 18;
  localparam int unsigned DenW   = 14;
  localparam int unsigned DurW   = 19;

  localparam logic [WholeW-1:0] WHOLE_MAX = WholeW'(240000);
  localparam logic [DenW-1:0]   DEN_MAX   = DenW'(9999);

  // Character codes
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SHARP = 8'h23;
  localparam logic [7:0] CH_FLAT  = 8'h5F;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_G = 8'h67;

  localparam logic [2:0] REST_IDX = 3'd7;

  typedef enum logic [2:0] {
    REG_WHOLE_NOTE = 3'd0,
    REG_DEFAULT_DEN = 3'd1,
    REG_DEFAULT_OCT = 3'd2,
    REG_FLAT_MASK = 3'd3,
    REG_SHARP_MASK = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_song;
  } in_t;

  typedef struct packed {
    logic [6:0]      note_number;
    logic            is_rest;
    logic [DurW-1:0] duration_ms;
    logic            slurred;
    logic            onset;
  } out_t;

  // Token handed from the parser to the duration unit
  typedef struct packed {
    logic [6:0]      note_number;
    logic            is_rest;
    logic [DenW-1:0] denominator;
    logic            dotted;
    logic            slurred;
    logic            onset;
  } tok_t;

  typedef struct packed {
    logic [WholeW-1:0] whole_note_ms;
    logic [DenW-1:0]   default_denominator;
    logic [2:0]        default_octave;
    logic [6:0]        auto_flat_mask;
    logic [6:0]        auto_sharp_mask;
  } cfg_t;

  // Semitone of letters a..g, counting c as 1
  function automatic logic [3:0] letter_base(input logic [2:0] idx);
    logic [3:0] s;
    unique case (idx)
      3'd0:    s = 4'd10;
      3'd1:    s = 4'd12;
      3'd2:    s = 4'd1;
      3'd3:    s = 4'd3;
      3'd4:    s = 4'd5;
      3'd5:    s = 4'd6;
      3'd6:    s = 4'd8;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== sv/rnp_front.sv =====
// ----------------------------------------------------------------------------
// rnp_front
// Character parser: classifies one character per cycle while the token queue
// has room and pushes a token record when a token ends.
// ----------------------------------------------------------------------------
`default_nettype none

module rnp_front import rnp_pkg::*; #(
  parameter int unsigned BASE_NOTE = 24
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  input  wire logic q_full_i,
  output logic      q_push_o,
  output tok_t      q_data_o
);

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_DIGITS  = 3'd1,
    PH_PREDOT  = 3'd2,
    PH_LETTER  = 3'd3,
    PH_POSTDOT = 3'd4,
    PH_ACC     = 3'd5,
    PH_MINUS   = 3'd6,
    PH_TAIL    = 3'd7
  } phase_e;

  phase_e            ph_q, ph_d;
  logic [DenW-1:0]   den_q, den_d;
  logic              dot_q, dot_d;
  logic signed [4:0] semi_q, semi_d;
  logic [2:0]        letter_q, letter_d;
  logic [2:0]        oct_q, oct_d;
  logic              minus_q, minus_d;
  logic              slur_q, slur_d;

  logic [7:0]  c;
  logic        is_ws, is_dig, is_sep, in_fire, emit;
  logic [3:0]  dval;
  logic [7:0]  flat8, sharp8;
  logic [16:0] den_acc;
  logic [2:0]  pidx;
  logic [4:0]  oct_sum;
  logic        rest;
  logic [2:0]  oct_m1;
  logic [6:0]  oct_x12;
  logic signed [9:0] nn;
  logic [6:0]  nn_sat;

  assign c       = in_data_i.character;
  assign is_ws   = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  assign is_dig  = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_sep  = (c == CH_COMMA) || (c == CH_PLUS);
  assign dval    = c[3:0];
  assign flat8   = {1'b0, cfg_i.auto_flat_mask};
  assign sharp8  = {1'b0, cfg_i.auto_sharp_mask};
  assign den_acc = 17'(den_q) * 17'd10 + 17'(dval);
  assign pidx    = c[2:0] - 3'd1;
  assign oct_sum = {2'b00, cfg_i.default_octave} + {1'b0, dval};

  assign in_ready_o = !q_full_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Next token state after this character
  always_comb begin
    ph_d     = ph_q;
    den_d    = den_q;
    dot_d    = dot_q;
    semi_d   = semi_q;
    letter_d = letter_q;
    oct_d    = oct_q;
    minus_d  = minus_q;
    slur_d   = slur_q;
    if (c == CH_COMMA) begin
      slur_d = 1'b0;
    end else if (c == CH_PLUS) begin
      slur_d = 1'b1;
    end
    if (is_sep) begin
      // hold: the separator closes the token as it stands
    end else if (ph_q < PH_LETTER) begin
      priority if (ph_q == PH_START && (is_ws || c == CH_COLON)) begin
        // skip leading filler
      end else if (ph_q != PH_PREDOT && is_dig) begin
        den_d = (den_acc > 17'(DEN_MAX)) ? DEN_MAX : den_acc[DenW-1:0];
        ph_d  = PH_DIGITS;
      end else if (ph_q != PH_PREDOT && c == CH_DOT) begin
        dot_d = 1'b1;
        ph_d  = PH_PREDOT;
      end else begin
        oct_d = cfg_i.default_octave;
        ph_d  = PH_LETTER;
        if (c >= CH_LOW_A && c <= CH_LOW_G) begin
          letter_d = pidx;
          semi_d   = $signed({1'b0, letter_base(pidx)});
          if (flat8[pidx]) begin
            semi_d = semi_d - 5'sd1;
          end else if (sharp8[pidx]) begin
            semi_d = semi_d + 5'sd1;
          end
        end else begin
          letter_d = REST_IDX;
          semi_d   = 5'sd0;
        end
      end
    end else begin
      priority if (is_ws) begin
        ph_d = PH_TAIL;
      end else if (c == CH_DOT && ph_q == PH_LETTER) begin
        dot_d = 1'b1;
        ph_d  = PH_POSTDOT;
      end else if ((c == CH_SHARP || c == CH_FLAT) && ph_q <= PH_POSTDOT) begin
        if (letter_q != REST_IDX) begin
          if (c == CH_SHARP && !sharp8[letter_q]) begin
            semi_d = semi_q + 5'sd1;
          end else if (c == CH_FLAT && !flat8[letter_q]) begin
            semi_d = semi_q - 5'sd1;
          end
        end
        ph_d = PH_ACC;
      end else if (c == CH_MINUS && ph_q <= PH_ACC) begin
        minus_d = 1'b1;
        ph_d    = PH_MINUS;
      end else if (is_dig && ph_q <= PH_MINUS) begin
        if (minus_q) begin
          oct_d = (dval + 4'd1 > {1'b0, cfg_i.default_octave}) ?
                  3'd1 : 3'(cfg_i.default_octave - dval[2:0]);
        end else begin
          oct_d = (oct_sum > 5'd7) ? 3'd7 : oct_sum[2:0];
        end
        ph_d = PH_TAIL;
      end else begin
        // drop unexpected characters
      end
    end
  end

  assign emit = in_fire && (is_sep || (in_data_i.end_of_song && ph_d != PH_START));

  // Pitch of the token as it leaves
  assign rest    = (ph_d < PH_LETTER) || (letter_d == REST_IDX);
  assign oct_m1  = oct_d - 3'd1;
  assign oct_x12 = {1'b0, oct_m1, 3'b000} + {2'b00, oct_m1, 2'b00};
  assign nn      = $signed(10'(BASE_NOTE)) - 10'sd1 + $signed({3'b000, oct_x12})
                 + {{5{semi_d[4]}}, semi_d};
  assign nn_sat  = (nn < 10'sd0) ? 7'd0 : (nn > 10'sd127) ? 7'd127 : nn[6:0];

  always_comb begin
    q_data_o.note_number = rest ? 7'd0 : nn_sat;
    q_data_o.is_rest     = rest;
    q_data_o.denominator = (den_d != '0) ? den_d : cfg_i.default_denominator;
    q_data_o.dotted      = dot_d;
    q_data_o.slurred     = (c == CH_PLUS);
    q_data_o.onset       = rest ? slur_q : !slur_q;
  end
  assign q_push_o = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q     <= PH_START;
      den_q    <= '0;
      dot_q    <= 1'b0;
      semi_q   <= 5'sd0;
      letter_q <= 3'd0;
      oct_q    <= 3'd4;
      minus_q  <= 1'b0;
      slur_q   <= 1'b0;
    end else if (in_fire) begin
      oct_q  <= oct_d;
      slur_q <= slur_d;
      if (emit) begin
        ph_q     <= PH_START;
        den_q    <= '0;
        dot_q    <= 1'b0;
        semi_q   <= 5'sd0;
        letter_q <= 3'd0;
        minus_q  <= 1'b0;
      end else begin
        ph_q     <= ph_d;
        den_q    <= den_d;
        dot_q    <= dot_d;
        semi_q   <= semi_d;
        letter_q <= letter_d;
        minus_q  <= minus_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/rnp_fifo.sv =====
// ----------------------------------------------------------------------------
// rnp_fifo
// Two-entry token queue between the parser and the duration unit.
// ----------------------------------------------------------------------------
`default_nettype none

module rnp_fifo import rnp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire tok_t push_data_i,
  output logic      full_o,
  output logic      valid_o,
  input  wire logic pop_i,
  output tok_t      pop_data_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);

  tok_t               mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]      count_q;
  logic               do_push, do_pop;

  assign full_o     = (count_q == (PtrW+1)'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (PtrW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (PtrW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/rnp_back.sv =====
// ----------------------------------------------------------------------------
// rnp_back
// Duration unit: divides the whole-note length by the token denominator one
// quotient bit per cycle, adds the dot extension and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rnp_back import rnp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic q_valid_i,
  output logic      q_pop_o,
  input  wire tok_t q_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  localparam int unsigned Steps = WholeW;
  localparam int unsigned CntW  = $clog2(Steps);

  typedef enum logic [1:0] {
    B_IDLE   = 2'd0,
    B_DIV    = 2'd1,
    B_FINISH = 2'd2
  } bstate_e;

  bstate_e         state_q;
  tok_t            tok_q;
  logic [WholeW-1:0] quo_q;
  logic [DenW-1:0] rem_q;
  logic [CntW-1:0] cnt_q;
  logic            out_valid_q;
  out_t            out_q;

  logic [DenW:0]   rem_sh;
  logic            q_bit;
  logic [DurW-1:0] dur;
  logic            load_out;

  assign rem_sh = {rem_q, quo_q[WholeW-1]};
  assign q_bit  = (rem_sh >= {1'b0, tok_q.denominator});
  assign dur    = {1'b0, quo_q} + (tok_q.dotted ? {2'b00, quo_q[WholeW-1:1]} : '0);

  assign q_pop_o     = (state_q == B_IDLE) && q_valid_i;
  assign load_out    = (state_q == B_FINISH) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.note_number <= tok_q.note_number;
      out_q.is_rest     <= tok_q.is_rest;
      out_q.duration_ms <= dur;
      out_q.slurred     <= tok_q.slurred;
      out_q.onset       <= tok_q.onset;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      tok_q       <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (q_valid_i) begin
            tok_q   <= q_data_i;
            quo_q   <= cfg_i.whole_note_ms;
            rem_q   <= '0;
            cnt_q   <= CntW'(Steps - 1);
            state_q <= B_DIV;
          end
        end
        B_DIV: begin
          // shift in one dividend bit, subtract when the divisor fits
          rem_q <= q_bit ? DenW'(rem_sh - {1'b0, tok_q.denominator}) : rem_sh[DenW-1:0];
          quo_q <= {quo_q[WholeW-2:0], q_bit};
          cnt_q <= cnt_q - CntW'(1);
          if (cnt_q == '0) begin
            state_q <= B_FINISH;
          end
        end
        B_FINISH: begin
          if (load_out) begin
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/ringtone_note_parser.sv =====
// ----------------------------------------------------------------------------
// ringtone_note_parser
// Ringtone note-section parser: characters in, one note record per token out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one character per transaction, end_of_song set on the last one.
//           A character is taken in the cycle it is offered while the
//           two-entry token queue has room.
//   out_* : one note record per token (',' or '+' or end of song closes it).
//   cfg_* : register writes, always ready; write only while the block idles.
// Timing: a token leaves the parser in the cycle of its closing character
//   and is queued; the duration unit then loads it, runs the bit-serial
//   divide and, in its finish state, adds the dot extension and loads the
//   output record.
// Throughput: the duration unit takes no new token before the last record is
//   loaded, so the serial divider sets the token rate; with several characters
//   to a token the parser meets about one character per cycle until the queue fills.
// Reset: token state, slur state, queue and output valid are cleared; registers
//   return to their reset values.
// Receiver stall: the record holds on out_data_o, the divider waits, the
//   queue fills and in_ready_o then drops.
// ----------------------------------------------------------------------------
`default_nettype none

module ringtone_note_parser import rnp_pkg::*; #(
  parameter int unsigned BASE_NOTE = 24
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire in_t               in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output out_t                   out_data_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [WholeW-1:0] cfg_data_i
);

  cfg_t cfg_q;
  logic q_full, q_push, q_valid, q_pop;
  tok_t q_push_data, q_pop_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.whole_note_ms       <= WholeW'(2400);
      cfg_q.default_denominator <= DenW'(1);
      cfg_q.default_octave      <= 3'd4;
      cfg_q.auto_flat_mask      <= '0;
      cfg_q.auto_sharp_mask     <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_WHOLE_NOTE: begin
          cfg_q.whole_note_ms <= (cfg_data_i > WHOLE_MAX) ? WHOLE_MAX : cfg_data_i;
        end
        REG_DEFAULT_DEN: begin
          // ignore zero, saturate large values
          if (cfg_data_i[DenW-1:0] != '0) begin
            cfg_q.default_denominator <= (cfg_data_i[DenW-1:0] > DEN_MAX) ?
                                         DEN_MAX : cfg_data_i[DenW-1:0];
          end
        end
        REG_DEFAULT_OCT: begin
          if (cfg_data_i[2:0] != 3'd0) begin
            cfg_q.default_octave <= cfg_data_i[2:0];
          end
        end
        REG_FLAT_MASK:  cfg_q.auto_flat_mask  <= cfg_data_i[6:0];
        REG_SHARP_MASK: cfg_q.auto_sharp_mask <= cfg_data_i[6:0];
        default: begin
        end
      endcase
    end
  end

  rnp_front #(
    .BASE_NOTE (BASE_NOTE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_push_data)
  );

  rnp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data)
  );

  rnp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_data_i    (q_pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
